/* design/epf_pkg.sv */
// Shared constants for the emirp pair finder.
// No dependencies; imported by the top level.
package epf_pkg;

   // Width of a limit or a prime in a transaction.
   localparam int VAL_W = 10;
   localparam int MAX_FIELD = (1 << VAL_W) - 1;

   // A four-digit value reverses to at most 9999.
   localparam int REV_W = 14;

   // Results per run and the width of their counter.
   localparam int RES_CAP = 18;
   localparam int CNT_W = 5;

   // Division by ten as (v * 205) >> 11, exact for v below 1029.
   localparam int DIV10_MUL = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int PROD_W = 18;
   localparam int DIGIT_W = 4;

endpackage

/* design/epf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by the emirp pair finder for its prime bitmap.
module epf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/emirp_pair_finder.sv */
// Emirp pair finder: one run per request transaction, up to 18 result transactions.
// Work per run: bitmap init over 0..limit, sieve marking, a scan of the values from 2 to
// the limit and, per prime, up to four digit steps of reversal and, if in range, a partner
// lookup. Result stalls hold the run. The bitmap RAM accesses set the run time.
// One run at a time.
// Reset (synchronous, active high) clears the sequencer, the result count and the valid flags;
// the bitmap is rewritten by every run and needs no clearing.
module emirp_pair_finder #(
   parameter int MAX_LIMIT = 1023
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [epf_pkg::VAL_W-1:0]   req_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [epf_pkg::VAL_W-1:0]   rsp_first_prime,
   output logic [epf_pkg::VAL_W-1:0]   rsp_second_prime,
   output logic                        rsp_last
);

   import epf_pkg::*;

   localparam int EFF_MAX = (MAX_LIMIT < MAX_FIELD) ? MAX_LIMIT : MAX_FIELD;
   localparam int DEPTH = EFF_MAX + 1;
   localparam int AW = $clog2(DEPTH);
   localparam int NW = AW + 1;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_INIT   = 11'b000_0000_0010,
      ST_SV_RD  = 11'b000_0000_0100,
      ST_SV_CHK = 11'b000_0000_1000,
      ST_MARK   = 11'b000_0001_0000,
      ST_SC_RD  = 11'b000_0010_0000,
      ST_SC_CHK = 11'b000_0100_0000,
      ST_REV    = 11'b000_1000_0000,
      ST_RV_CHK = 11'b001_0000_0000,
      ST_EMIT   = 11'b010_0000_0000,
      ST_FIN    = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       lim_ff, lim_in;
   logic [NW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       p_ff, p_in;
   logic [NW-1:0]       sq_ff, sq_in;
   logic [AW-1:0]       v_ff, v_in;
   logic [REV_W-1:0]    r_ff, r_in;
   logic                pend_v_ff, pend_v_in;
   logic [VAL_W-1:0]    pend_a_ff, pend_a_in;
   logic [VAL_W-1:0]    pend_b_ff, pend_b_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [VAL_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [VAL_W-1:0]    rsp_second_ff, rsp_second_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en, wr_data, rd_en, rd_data;
   logic [AW-1:0]       wr_addr, rd_addr;

   logic [VAL_W-1:0]    lim_sat;
   logic [PROD_W-1:0]   prod;
   logic [AW-1:0]       quot, quot10;
   logic [DIGIT_W-1:0]  digit;
   logic [REV_W-1:0]    r_step;
   logic [NW-1:0]       mark_next, sq_next;
   logic                out_free;

   epf_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign lim_sat = (req_limit > VAL_W'(EFF_MAX)) ? VAL_W'(EFF_MAX) : req_limit;

   // One decimal digit per cycle: quotient by reciprocal, remainder by subtraction.
   assign prod   = PROD_W'(v_ff) * PROD_W'(DIV10_MUL);
   assign quot   = AW'(prod >> DIV10_SHIFT);
   assign quot10 = AW'((quot << 3) + (quot << 1));
   assign digit  = DIGIT_W'(v_ff - quot10);
   assign r_step = REV_W'((r_ff << 3) + (r_ff << 1) + REV_W'(digit));

   assign mark_next = idx_ff + NW'(p_ff);
   assign sq_next   = sq_ff + NW'({p_ff, 1'b1});
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      lim_in        = lim_ff;
      idx_in        = idx_ff;
      p_in          = p_ff;
      sq_in         = sq_ff;
      v_in          = v_ff;
      r_in          = r_ff;
      pend_v_in     = pend_v_ff;
      pend_a_in     = pend_a_ff;
      pend_b_in     = pend_b_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lim_in    = AW'(lim_sat);
               idx_in    = '0;
               count_in  = '0;
               pend_v_in = 1'b0;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = (idx_ff >= NW'(2));
            if (idx_ff == NW'(lim_ff)) begin
               p_in     = AW'(2);
               sq_in    = NW'(4);
               state_in = ST_SV_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SV_RD: begin
            if (sq_ff > NW'(lim_ff)) begin
               idx_in   = NW'(2);
               state_in = ST_SC_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = p_ff;
               state_in = ST_SV_CHK;
            end
         end
         ST_SV_CHK: begin
            if (rd_data) begin
               idx_in   = {p_ff, 1'b0};
               state_in = ST_MARK;
            end else begin
               sq_in    = sq_next;
               p_in     = p_ff + 1'b1;
               state_in = ST_SV_RD;
            end
         end
         ST_MARK: begin
            wr_en = 1'b1;
            if (mark_next > NW'(lim_ff)) begin
               sq_in    = sq_next;
               p_in     = p_ff + 1'b1;
               state_in = ST_SV_RD;
            end else begin
               idx_in = mark_next;
            end
         end
         ST_SC_RD: begin
            if (idx_ff > NW'(lim_ff)) begin
               state_in = ST_FIN;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_SC_CHK;
            end
         end
         ST_SC_CHK: begin
            if (rd_data) begin
               v_in     = idx_ff[AW-1:0];
               r_in     = '0;
               state_in = ST_REV;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_REV: begin
            if (v_ff != '0) begin
               v_in = quot;
               r_in = r_step;
            end else if (r_ff != REV_W'(idx_ff) && r_ff <= REV_W'(lim_ff)) begin
               rd_en    = 1'b1;
               rd_addr  = r_ff[AW-1:0];
               state_in = ST_RV_CHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_RV_CHK: begin
            if (rd_data) begin
               // Clear the partner so the pair is not reported again from its side.
               wr_en    = 1'b1;
               wr_addr  = r_ff[AW-1:0];
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_EMIT: begin
            // A pair is held back until the next one shows up, so that the final
            // transaction of the run can carry the last flag.
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = 1'b1;
                  rsp_first_in  = pend_a_ff;
                  rsp_second_in = pend_b_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_v_in = 1'b1;
               pend_a_in = VAL_W'(idx_ff);
               pend_b_in = VAL_W'(r_ff);
               count_in  = count_ff + 1'b1;
               idx_in    = idx_ff + 1'b1;
               if (count_ff == CNT_W'(RES_CAP - 1)) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SC_RD;
               end
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = pend_v_ff;
               rsp_first_in  = pend_v_ff ? pend_a_ff : '0;
               rsp_second_in = pend_v_ff ? pend_b_ff : '0;
               rsp_last_in   = 1'b1;
               pend_v_in     = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_v_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_v_ff    <= pend_v_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff        <= lim_in;
      idx_ff        <= idx_in;
      p_ff          <= p_in;
      sq_ff         <= sq_in;
      v_ff          <= v_in;
      r_ff          <= r_in;
      pend_a_ff     <= pend_a_in;
      pend_b_ff     <= pend_b_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_first_prime  = rsp_first_ff;
   assign rsp_second_prime = rsp_second_ff;
   assign rsp_last         = rsp_last_ff;

   a_pair_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_first_prime < rsp_second_prime)
      else $error("pair reported with the larger prime first");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("empty result without the last flag");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RES_CAP))
      else $error("result count above its cap");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> pend_v_ff == 1'b0)
      else $error("held pair survived into a new run");

endmodule
